// File: hw/rtl/assert_macros.svh
// Assertion macros included by the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/exctp_pkg.sv
// Package with the types, constants and helper functions of the exclusive-time profiler.
package exctp_pkg;

    localparam int NUM_FUNCS   = 128;
    localparam int STACK_DEPTH = 64;

    localparam int ID_W    = 7;
    localparam int TS_W    = 32;
    localparam int MARK_W  = 33;
    localparam int TOTAL_W = 40;

    localparam int FUNC_AW = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
    localparam int SD_W    = $clog2(STACK_DEPTH + 1);
    localparam int SA_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_BACK  = 2'd3;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [1:0]      func;
        logic [ID_W-1:0] routine_id;
        logic [TS_W-1:0] timestamp;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]    charged_id;
        logic [TOTAL_W-1:0] total_time;
        logic               charged;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_UPDATE
    } t_state;

    // Request from the sequencer to the totals unit, issued in the lookup cycle.
    typedef struct packed {
        logic               issue;
        logic               charge;
        logic [FUNC_AW-1:0] addr;
        logic [MARK_W-1:0]  delta;
    } t_acc_req;

    function automatic logic [FUNC_AW-1:0] func_addr(input logic [ID_W-1:0] id);
        logic [FUNC_AW+ID_W-1:0] ext;
        ext = {{FUNC_AW{1'b0}}, id};
        return ext[FUNC_AW-1:0];
    endfunction

    function automatic logic id_in_range(input logic [ID_W-1:0] id);
        return int'(id) < NUM_FUNCS;
    endfunction

endpackage

// File: hw/rtl/exctp_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module exctp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/exctp_acc.sv
// Totals unit: per-function exclusive-time memory with valid bits and a saturating update.
module exctp_acc (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  exctp_pkg::t_acc_req               i_req,
    input  logic                              i_commit,
    output logic [exctp_pkg::TOTAL_W-1:0]     o_total
);
    import exctp_pkg::*;

    logic [NUM_FUNCS-1:0] r_valid;
    logic [NUM_FUNCS-1:0] n_valid;
    logic                 r_hit;
    logic                 r_charge;
    logic [FUNC_AW-1:0]   r_addr;
    logic [MARK_W-1:0]    r_delta;

    logic [TOTAL_W-1:0] ram_rdata;
    logic [TOTAL_W-1:0] base;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] updated;
    logic               we;

    exctp_ram #(
        .WIDTH (TOTAL_W),
        .DEPTH (NUM_FUNCS)
    ) u_totals (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_addr),
        .i_wdata (updated),
        .i_re    (i_req.issue),
        .i_raddr (i_req.addr),
        .o_rdata (ram_rdata)
    );

    // An entry never written since reset reads as zero.
    assign base    = r_hit ? ram_rdata : '0;
    assign sum     = {1'b0, base} + (TOTAL_W + 1)'(r_delta);
    assign updated = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    assign we      = i_commit && r_charge;
    assign o_total = r_charge ? updated : base;

    always_comb begin
        n_valid = r_valid;
        if (we) begin
            n_valid[r_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_charge <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_req.issue) begin
                r_charge <= i_req.charge;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.issue) begin
            r_hit   <= r_valid[i_req.addr];
            r_addr  <= i_req.addr;
            r_delta <= i_req.delta;
        end
    end

endmodule

// File: hw/rtl/exclusive_time_call_stack_profiler_unit.sv
// Top level of the exclusive-time call-stack profiler: sequencer, call stack and result register.
//
// Trace events arrive on the input channel (i_valid, i_data, o_stall) and each one
// produces exactly one result on the output channel (o_valid, o_data, i_stall).
// A transfer happens at a rising edge where valid is high and stall is low.
// An event goes through three steps: on acceptance the call stack memory is read at its top,
// in the lookup state the function's total is read from the totals memory, and at the end
// of the write-back state the saturated sum is written back and the result is registered.
// The write-back state of one event is also where the next event can be accepted, so the
// block takes a new event before it has finished the last one, unless the receiver stalls.
// The result register holds one finished result while the next event is looked up;
// a stalled receiver holds the block in its write-back cycle until the register frees.
// Reset empties the stack, clears the time mark and marks every total as zero
// through per-function valid bits, so no clearing pass is needed.
module exclusive_time_call_stack_profiler_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  exctp_pkg::t_in_item   i_data,
    output logic                  o_stall,
    output logic                  o_valid,
    output exctp_pkg::t_out_item  o_data,
    input  logic                  i_stall
);
    import exctp_pkg::*;

`include "assert_macros.svh"

    t_state             r_state;
    t_state             n_state;
    t_in_item           r_item;
    logic [SD_W-1:0]    r_depth;
    logic [SD_W-1:0]    n_depth;
    logic [MARK_W-1:0]  r_mark;
    logic [MARK_W-1:0]  n_mark;
    logic [1:0]         r_status;
    logic               r_charged;
    logic [ID_W-1:0]    r_cid;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               accept;
    logic               commit;
    logic               out_free;
    logic               look;

    logic [SD_W-1:0]    depth_m1;
    logic [ID_W-1:0]    top_id;
    logic               is_start;
    logic               is_end;
    logic               is_read;
    logic               empty;
    logic               full;
    logic [MARK_W-1:0]  end_mark;
    logic               backward;
    logic [MARK_W-1:0]  delta;
    logic [ID_W-1:0]    tgt_id;
    logic               do_charge;
    logic               tgt_ok;
    logic               push;
    logic               pop;
    logic [1:0]         status;
    t_acc_req           acc_req;
    logic [TOTAL_W-1:0] acc_total;
    t_out_item          result;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (out_free) begin
                    n_state = i_valid ? S_LOOK : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        look    = 1'b0;
        commit  = 1'b0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
            end
            S_LOOK: begin
                look = 1'b1;
            end
            S_UPDATE: begin
                commit  = out_free;
                o_stall = !out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    assign out_free = !r_out_valid || !i_stall;
    assign accept   = i_valid && !o_stall;
    assign depth_m1 = r_depth - SD_W'(1);

    exctp_ram #(
        .WIDTH (ID_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (look && push),
        .i_waddr (r_depth[SA_W-1:0]),
        .i_wdata (r_item.routine_id),
        .i_re    (accept),
        .i_raddr (depth_m1[SA_W-1:0]),
        .o_rdata (top_id)
    );

    // Lookup cycle: decide the charge and update the stack and the time mark.
    always_comb begin
        is_start  = r_item.func == KIND_START;
        is_end    = r_item.func == KIND_END;
        is_read   = r_item.func == KIND_READ;
        empty     = r_depth == '0;
        full      = int'(r_depth) >= STACK_DEPTH;
        end_mark  = {1'b0, r_item.timestamp} + (is_end ? MARK_W'(1) : MARK_W'(0));
        backward  = end_mark < r_mark;
        delta     = backward ? '0 : end_mark - r_mark;
        tgt_id    = is_read ? r_item.routine_id : top_id;
        tgt_ok    = id_in_range(tgt_id);
        push      = is_start && !full;
        pop       = is_end && !empty;
        do_charge = (push && !empty) || pop;

        if (is_start && full) begin
            status = STAT_FULL;
        end else if (is_end && empty) begin
            status = STAT_EMPTY;
        end else if (do_charge && backward) begin
            status = STAT_BACK;
        end else begin
            status = STAT_OK;
        end

        acc_req.issue  = look;
        acc_req.charge = do_charge && tgt_ok;
        acc_req.addr   = func_addr(tgt_id);
        acc_req.delta  = delta;

        n_depth = r_depth;
        n_mark  = r_mark;
        if (look && push) begin
            n_depth = r_depth + SD_W'(1);
            n_mark  = end_mark;
        end else if (look && pop) begin
            n_depth = depth_m1;
            n_mark  = end_mark;
        end
    end

    exctp_acc u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (acc_req),
        .i_commit (commit),
        .o_total  (acc_total)
    );

    always_comb begin
        result.charged_id = r_charged ? r_cid : '0;
        result.total_time = r_charged ? acc_total : '0;
        result.charged    = r_charged;
        result.status     = r_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_mark      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_mark  <= n_mark;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_data;
        end
        if (look) begin
            r_status  <= status;
            r_charged <= (do_charge || is_read) && tgt_ok;
            r_cid     <= tgt_id;
        end
        if (commit) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `ASSERT_CLK(a_depth_bound, i_clk, i_rst_n, int'(r_depth) <= STACK_DEPTH, "stack depth overflow")
    `ASSERT_CLK(a_accept_look, i_clk, i_rst_n, accept |=> r_state == S_LOOK, "accepted event not looked up")
    `ASSERT_CLK(a_rose_update, i_clk, i_rst_n, $rose(o_valid) |-> $past(r_state) == S_UPDATE, "result without write-back")
    `ASSERT_CLK(a_full_nocharge, i_clk, i_rst_n, (o_valid && o_data.status == STAT_FULL) |-> !o_data.charged, "charge on full stack")

endmodule

// File: tb/sv/profile_checker.sv
// Checker for the exclusive-time profiler: predicts each result and compares it on transfer.
module profile_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ev_valid,
    input  logic                 i_ev_stall,
    input  exctp_pkg::t_in_item  i_ev_data,
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  exctp_pkg::t_out_item i_res_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_full_hits,
    output int                   o_sat_hits
);
    timeunit 1ns;
    timeprecision 1ps;
    import exctp_pkg::*;

    // Predicted profiler state.
    logic [ID_W-1:0]    frames [STACK_DEPTH];
    int unsigned        depth;
    logic [MARK_W-1:0]  last_mark;
    logic [TOTAL_W-1:0] func_totals [NUM_FUNCS];

    t_out_item awaited_reports [$];

    // Applies one trace event to the predicted state and returns the report it causes.
    function automatic t_out_item profile_event(input t_in_item ev);
        t_out_item          res;
        logic [ID_W-1:0]    top_id;
        logic [MARK_W-1:0]  stamp;
        logic [MARK_W-1:0]  delta;
        logic [TOTAL_W-1:0] room;
        logic               charge_it;
        res       = '0;
        top_id    = '0;
        delta     = '0;
        charge_it = 1'b0;
        stamp     = {1'b0, ev.timestamp};
        case (ev.func)
            KIND_START: begin
                if (depth >= STACK_DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    if (depth > 0) begin
                        top_id    = frames[SA_W'(depth - 1)];
                        charge_it = 1'b1;
                        if (stamp < last_mark) res.status = STAT_BACK;
                        else delta = stamp - last_mark;
                    end
                    frames[SA_W'(depth)] = ev.routine_id;
                    depth++;
                    last_mark = stamp;
                end
            end
            KIND_END: begin
                if (depth == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    // The end mark is one past the timestamp, carried into the 33rd bit.
                    stamp     = stamp + MARK_W'(1);
                    top_id    = frames[SA_W'(depth - 1)];
                    charge_it = 1'b1;
                    if (stamp < last_mark) res.status = STAT_BACK;
                    else delta = stamp - last_mark;
                    depth--;
                    last_mark = stamp;
                end
            end
            KIND_READ: begin
                if (int'(ev.routine_id) < NUM_FUNCS) begin
                    res.charged    = 1'b1;
                    res.charged_id = ev.routine_id;
                    res.total_time = func_totals[ev.routine_id];
                end
            end
            default: ;
        endcase
        if (charge_it && int'(top_id) < NUM_FUNCS) begin
            room = TOTAL_MAX - func_totals[top_id];
            if (TOTAL_W'(delta) >= room) func_totals[top_id] = TOTAL_MAX;
            else func_totals[top_id] = func_totals[top_id] + TOTAL_W'(delta);
            res.charged    = 1'b1;
            res.charged_id = top_id;
            res.total_time = func_totals[top_id];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            depth     = 0;
            last_mark = '0;
            for (int f = 0; f < NUM_FUNCS; f++) func_totals[FUNC_AW'(f)] = '0;
            awaited_reports.delete();
        end else begin
            if (i_ev_valid && !i_ev_stall) begin
                want = profile_event(i_ev_data);
                if (want.status == STAT_FULL) o_full_hits++;
                if (want.charged && want.total_time == TOTAL_MAX) o_sat_hits++;
                awaited_reports.push_back(want);
            end
            if (i_res_valid && !i_res_stall) begin
                if (awaited_reports.size() == 0) begin
                    $error("result transfer with no result awaited");
                    o_fail_count++;
                end else begin
                    want = awaited_reports.pop_front();
                    o_checked++;
                    if (i_res_data.charged_id !== want.charged_id) begin
                        $error("charged_id: expected %0d, actual %0d",
                               want.charged_id, i_res_data.charged_id);
                        o_fail_count++;
                    end
                    if (i_res_data.total_time !== want.total_time) begin
                        $error("total_time: expected %0d, actual %0d",
                               want.total_time, i_res_data.total_time);
                        o_fail_count++;
                    end
                    if (i_res_data.charged !== want.charged) begin
                        $error("charged: expected %0d, actual %0d",
                               want.charged, i_res_data.charged);
                        o_fail_count++;
                    end
                    if (i_res_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, i_res_data.status);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = awaited_reports.size();
    end

endmodule

// File: tb/sv/testbench.sv
// Top of the profiler testbench: clock, reset, trace stimulus, receiver stalls and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import exctp_pkg::*;

    localparam int ITEM_TARGET = 1950;
    localparam int CYCLE_LIMIT = 400000;
    localparam int QUIET_FROM  = 3000;
    localparam int QUIET_TO    = 4500;
    localparam int SAT_PAIRS   = 260;

    logic      i_clk;
    logic      i_rst_n  = 1'b0;
    logic      i_valid  = 1'b0;
    t_in_item  i_data   = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_data;
    logic      i_stall  = 1'b0;

    int fail_count;
    int pending;
    int checked;
    int full_hits;
    int sat_hits;

    int          cycle_count = 0;
    int          sent_count  = 0;
    int          stack_level = 0;
    logic [31:0] now         = '0;
    logic [6:0]  last_id     = '0;
    logic        steady;

    exclusive_time_call_stack_profiler_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    profile_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ev_valid   (i_valid),
        .i_ev_stall   (o_stall),
        .i_ev_data    (i_data),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_res_data   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_hits  (full_hits),
        .o_sat_hits   (sat_hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Neither side inserts random idles inside this window of cycles.
    assign steady = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_stall <= !steady && ($urandom_range(0, 99) < 33);
    end

    function automatic t_in_item trace_event(input logic [1:0] kind, input logic [6:0] id,
                                             input logic [31:0] ts);
        t_in_item ev;
        ev.func       = kind;
        ev.routine_id = id;
        ev.timestamp  = ts;
        return ev;
    endfunction

    task automatic send_event(input t_in_item ev);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 33) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= ev;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
        if (ev.func == KIND_START && stack_level < STACK_DEPTH) stack_level++;
        else if (ev.func == KIND_END && stack_level > 0) stack_level--;
        if (ev.func == KIND_START) last_id = ev.routine_id;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int          pick;
        int          sel;
        bit          sat_done;
        int          fills;
        logic [6:0]  id;
        logic [31:0] ts;
        sat_done = 1'b0;
        fills    = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty stack, extreme ids and times, backwards time, the unused kind.
        send_event(trace_event(KIND_END,   7'd0,   32'd0));
        send_event(trace_event(KIND_READ,  7'd0,   32'd0));
        send_event(trace_event(KIND_READ,  7'd127, 32'hFFFF_FFFF));
        send_event(trace_event(2'd3,       7'd127, 32'hFFFF_FFFF));
        send_event(trace_event(KIND_START, 7'd5,   32'd100));
        send_event(trace_event(KIND_START, 7'd127, 32'd250));
        send_event(trace_event(KIND_START, 7'd0,   32'd200));
        send_event(trace_event(KIND_END,   7'd0,   32'd299));
        // An end at the top timestamp moves the mark past 32 bits.
        send_event(trace_event(KIND_END,   7'd0,   32'hFFFF_FFFF));
        send_event(trace_event(KIND_START, 7'd9,   32'hFFFF_FFFF));
        send_event(trace_event(KIND_END,   7'd127, 32'hFFFF_FFFF));
        send_event(trace_event(KIND_END,   7'd0,   32'd10));
        send_event(trace_event(KIND_END,   7'd0,   32'd20));
        send_event(trace_event(KIND_READ,  7'd127, 32'd0));
        send_event(trace_event(KIND_READ,  7'd5,   32'd0));
        send_event(trace_event(KIND_READ,  7'd0,   32'd0));
        send_event(trace_event(KIND_READ,  7'd9,   32'd0));
        drain_results();
        now = 32'd1000;

        while (sent_count < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 3 && fills < 3) begin
                // Fill the stack, overflow it, then unwind past empty.
                fills++;
                while (stack_level < STACK_DEPTH) begin
                    now = now + $urandom_range(1, 500);
                    send_event(trace_event(KIND_START, 7'($urandom), now));
                end
                repeat (2) send_event(trace_event(KIND_START, 7'($urandom), now));
                while (stack_level > 0) begin
                    now = now + $urandom_range(1, 500);
                    send_event(trace_event(KIND_END, 7'($urandom), now));
                end
                send_event(trace_event(KIND_END, 7'($urandom), now));
            end else if (pick < 5 && !sat_done && sent_count > 400
                         && stack_level < STACK_DEPTH - 2) begin
                // Each pair charges the same function almost 2^32 ticks, driving it to saturation.
                sat_done = 1'b1;
                id = 7'($urandom);
                send_event(trace_event(KIND_START, id, now));
                repeat (SAT_PAIRS) begin
                    send_event(trace_event(KIND_START, 7'($urandom), 32'hFFFF_FFFF));
                    send_event(trace_event(KIND_END, 7'($urandom), 32'd0));
                end
                send_event(trace_event(KIND_READ, id, 32'($urandom)));
                send_event(trace_event(KIND_END, id, 32'hFFFF_FFFF));
                send_event(trace_event(KIND_READ, id, 32'($urandom)));
                now = 32'd0;
            end else if (pick < 7) begin
                drain_results();
            end else begin
                sel = $urandom_range(0, 99);
                ts  = now + (($urandom_range(0, 9) == 0) ? $urandom_range(1, 24'hFF_FFFF)
                                                         : $urandom_range(1, 2000));
                if (sel < 38) begin
                    now = ts;
                    send_event(trace_event(KIND_START, 7'($urandom), ts));
                end else if (sel < 76) begin
                    now = ts;
                    send_event(trace_event(KIND_END, 7'($urandom), ts));
                end else if (sel < 90) begin
                    id = $urandom_range(0, 1) ? last_id : 7'($urandom);
                    send_event(trace_event(KIND_READ, id, 32'($urandom)));
                end else if (sel < 96) begin
                    // Noise: arbitrary timestamps, often running backwards.
                    send_event(trace_event(2'($urandom_range(0, 1)), 7'($urandom),
                                           32'($urandom)));
                end else begin
                    send_event(trace_event(2'd3, 7'($urandom), 32'($urandom)));
                end
            end
        end

        drain_results();
        repeat (8) @(negedge i_clk);
        $display("Run covered %0d trace events and %0d checked results.", sent_count, checked);
        $display("Stack overflowed %0d times; %0d results showed a saturated total.",
                 full_hits, sat_hits);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
